// ===== hw/rtl/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg: shared types, constants and microcode for the prime sum block
// Holds the control word format, the condition codes, the step numbers
// and the read-only program that the sequencer steps through.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int LIMIT_BITS_DEF = 12;
  localparam int SUM_W          = 32;
  localparam int CAND_FIRST     = 2;
  localparam int DIV_FIRST      = 3;
  localparam int DIV_STRIDE     = 2;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Step numbers of the program
  localparam step_t S_IDLE = 4'd0;
  localparam step_t S_CHK  = 4'd1;
  localparam step_t S_TWO  = 4'd2;
  localparam step_t S_EVEN = 4'd3;
  localparam step_t S_LOOP = 4'd4;
  localparam step_t S_DIV  = 4'd5;
  localparam step_t S_WAIT = 4'd6;
  localparam step_t S_TEST = 4'd7;
  localparam step_t S_BACK = 4'd8;
  localparam step_t S_ADD  = 4'd9;
  localparam step_t S_NEXT = 4'd10;
  localparam step_t S_DONE = 4'd11;

  // Jump conditions: jump to target when true, else fall through
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_START,
    C_CAND_GT_N,
    C_CAND_TWO,
    C_CAND_EVEN,
    C_DIV_END,
    C_REM_BUSY,
    C_REM_ZERO
  } cond_t;

  // Datapath actions of one step
  typedef struct packed {
    logic load;
    logic div_init;
    logic rem_start;
    logic div_inc;
    logic acc_add;
    logic cand_inc;
    logic finish;
  } act_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    act_t  act;
  } uword_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic start;
    logic cand_gt_n;
    logic cand_two;
    logic cand_even;
    logic div_end;
    logic rem_busy;
    logic rem_zero;
  } flags_t;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '0;
    w.cond   = C_NEVER;
    w.target = S_IDLE;
    case (s)
      S_IDLE: begin
        w.cond = C_NOT_START; w.target = S_IDLE; w.act.load = 1'b1;
      end
      S_CHK: begin
        w.cond = C_CAND_GT_N; w.target = S_DONE;
      end
      S_TWO: begin
        w.cond = C_CAND_TWO; w.target = S_ADD;
      end
      S_EVEN: begin
        w.cond = C_CAND_EVEN; w.target = S_NEXT; w.act.div_init = 1'b1;
      end
      S_LOOP: begin
        w.cond = C_DIV_END; w.target = S_ADD;
      end
      S_DIV: begin
        w.cond = C_NEVER; w.target = S_IDLE; w.act.rem_start = 1'b1;
      end
      S_WAIT: begin
        w.cond = C_REM_BUSY; w.target = S_WAIT;
      end
      S_TEST: begin
        w.cond = C_REM_ZERO; w.target = S_NEXT;
      end
      S_BACK: begin
        w.cond = C_ALWAYS; w.target = S_LOOP; w.act.div_inc = 1'b1;
      end
      S_ADD: begin
        w.cond = C_NEVER; w.target = S_IDLE; w.act.acc_add = 1'b1;
      end
      S_NEXT: begin
        w.cond = C_ALWAYS; w.target = S_CHK; w.act.cand_inc = 1'b1;
      end
      S_DONE: begin
        w.cond = C_ALWAYS; w.target = S_IDLE; w.act.finish = 1'b1;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/psu_rem.sv =====
// ----------------------------------------------------------------------------
// psu_rem: iterative remainder unit
// Restoring division, one dividend bit per cycle; flags a zero remainder.
// ----------------------------------------------------------------------------
module psu_rem #(
  parameter int W = psu_pkg::LIMIT_BITS_DEF + 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         rem_zero
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [W-1:0]  q;
  logic [W-1:0]  d;
  logic [W-1:0]  r;
  logic [W:0]    trial;
  logic          fits;

  assign trial = {r, q[W-1]};
  assign fits  = trial >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(W);
      q   <= dividend;
      d   <= divisor;
      r   <= '0;
    end else if (cnt != '0) begin
      // shift in the next dividend bit, subtract where it fits
      cnt <= cnt - CW'(1);
      q   <= {q[W-2:0], 1'b0};
      r   <= fits ? W'(trial - {1'b0, d}) : W'(trial);
    end
  end

  assign busy     = cnt != '0;
  assign rem_zero = r == '0;

endmodule

// ===== hw/rtl/psu_seq.sv =====
// ----------------------------------------------------------------------------
// psu_seq: microcode sequencer
// Step counter over the program table with conditional jumps.
// ----------------------------------------------------------------------------
module psu_seq (
  input  logic             clk,
  input  logic             rst,
  input  psu_pkg::flags_t  flags,
  output psu_pkg::act_t    act,
  output logic             busy
);

  psu_pkg::step_t  step;
  psu_pkg::step_t  step_next;
  psu_pkg::uword_t word;
  logic            take;

  assign word = psu_pkg::ucode(step);
  assign act  = word.act;
  assign busy = step != psu_pkg::S_IDLE;

  always_comb begin
    case (word.cond)
      psu_pkg::C_NEVER:     take = 1'b0;
      psu_pkg::C_ALWAYS:    take = 1'b1;
      psu_pkg::C_NOT_START: take = !flags.start;
      psu_pkg::C_CAND_GT_N: take = flags.cand_gt_n;
      psu_pkg::C_CAND_TWO:  take = flags.cand_two;
      psu_pkg::C_CAND_EVEN: take = flags.cand_even;
      psu_pkg::C_DIV_END:   take = flags.div_end;
      psu_pkg::C_REM_BUSY:  take = flags.rem_busy;
      psu_pkg::C_REM_ZERO:  take = flags.rem_zero;
      default:              take = 1'b1;
    endcase
    step_next = take ? word.target : step + psu_pkg::step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= psu_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== hw/rtl/prime_sum_up_to_limit.sv =====
// ----------------------------------------------------------------------------
// prime_sum_up_to_limit: sum of all primes up to an inclusive limit
// Timing: a limit below two finishes without trying any divisor; otherwise each
//   odd divisor tried runs through the bit-serial remainder unit, and each
//   candidate adds further sequencer steps.
// Throughput: one word at a time; busy stays high until the result strobe.
// Reset: synchronous, returns the sequencer to idle and clears the strobe.
// The receiver cannot stall: prime_sum is valid only while done is high.
// ----------------------------------------------------------------------------
// A microcoded sequencer steps through a short program held in the package.
// Each control word picks one jump condition and a set of datapath actions:
//   - load the limit, set the candidate to two and clear the sum
//   - reject candidates above the limit (finish), accept two at once,
//     reject other even candidates
//   - try odd divisors from three while the divisor is below candidate/2,
//     each through the iterative remainder unit; a zero remainder drops the
//     candidate, running out of divisors adds it to the sum
// The sum saturates at its all-ones value; with a limit of at most sixteen
// bits this never happens.
// ----------------------------------------------------------------------------
module prime_sum_up_to_limit #(
  parameter int LIMIT_BITS = psu_pkg::LIMIT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [LIMIT_BITS-1:0]      limit,
  output logic                       busy,
  output logic                       done,
  output logic [psu_pkg::SUM_W-1:0]  prime_sum
);

  // candidate runs up to limit+1, so give it one bit more
  localparam int W = LIMIT_BITS + 1;

  psu_pkg::flags_t flags;
  psu_pkg::act_t   act;

  logic [LIMIT_BITS-1:0]     n;
  logic [W-1:0]              cand;
  logic [W-1:0]              div;
  logic [psu_pkg::SUM_W-1:0] acc;
  logic [psu_pkg::SUM_W:0]   sum_wide;
  logic                      rem_busy;
  logic                      rem_zero;
  logic                      accept;

  assign accept = start && !busy;

  // Status for the jump conditions
  assign flags.start     = start;
  assign flags.cand_gt_n = cand > {1'b0, n};
  assign flags.cand_two  = cand == W'(psu_pkg::CAND_FIRST);
  assign flags.cand_even = !cand[0];
  assign flags.div_end   = div >= (cand >> 1);
  assign flags.rem_busy  = rem_busy;
  assign flags.rem_zero  = rem_zero;

  psu_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .act   (act),
    .busy  (busy)
  );

  psu_rem #(
    .W (W)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (act.rem_start),
    .dividend (cand),
    .divisor  (div),
    .busy     (rem_busy),
    .rem_zero (rem_zero)
  );

  assign sum_wide = {1'b0, acc} + (psu_pkg::SUM_W + 1)'(cand);

  // Datapath registers
  always_ff @(posedge clk) begin
    if (act.load && start) begin
      n    <= limit;
      cand <= W'(psu_pkg::CAND_FIRST);
      acc  <= '0;
    end else begin
      if (act.cand_inc) begin
        cand <= cand + W'(1);
      end
      if (act.acc_add) begin
        // hold at all ones on overflow
        acc <= sum_wide[psu_pkg::SUM_W] ? '1 : sum_wide[psu_pkg::SUM_W-1:0];
      end
    end
    if (act.div_init) begin
      div <= W'(psu_pkg::DIV_FIRST);
    end else if (act.div_inc) begin
      div <= div + W'(psu_pkg::DIV_STRIDE);
    end
  end

  // Result word and its one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= act.finish;
    end
    if (act.finish) begin
      prime_sum <= acc;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted word did not start the sequence");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe outside the end of a sequence");

  a_sum_grows: assert property (@(posedge clk) disable iff (rst)
    busy && $past(busy) |-> acc >= $past(acc))
    else $error("running sum fell while working");

  a_rem_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !rem_busy)
    else $error("remainder unit still running while idle");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for prime_sum_up_to_limit
// Drives limit words through the start/busy handshake, works out the prime
// sum of each accepted limit by trial division of its own, and compares
// every strobed result, in order, with the oldest sum still outstanding.
// ----------------------------------------------------------------------------

class prime_sum_tracker;
  bit [31:0] owed_sums[$];
  int unsigned mismatches;
  int unsigned compared;

  function new();
    mismatches = 0;
    compared   = 0;
  endfunction

  // odd divisors from three while below half the candidate
  static function bit trial_prime(int unsigned cand);
    int unsigned d;
    if (cand <= 1) return 1'b0;
    if (cand > 2 && cand % 2 == 0) return 1'b0;
    for (d = 3; d < cand / 2; d += 2)
      if (cand % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  static function bit [31:0] sum_primes_upto(bit [psu_pkg::LIMIT_BITS_DEF-1:0] n);
    longint unsigned acc;
    int unsigned c;
    acc = 0;
    for (c = 2; c <= n; c++)
      if (trial_prime(c)) begin
        acc += c;
        if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
      end
    return acc[31:0];
  endfunction

  function void note_limit(bit [psu_pkg::LIMIT_BITS_DEF-1:0] n);
    owed_sums.push_back(sum_primes_upto(n));
  endfunction

  function void check_sum(bit [31:0] got);
    bit [31:0] want;
    if (owed_sums.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %0d", $time, got);
      mismatches++;
      return;
    end
    want = owed_sums.pop_front();
    compared++;
    if (got !== want) begin
      $display("%0t: prime_sum mismatch, expected %0d, actual %0d", $time, want, got);
      mismatches++;
    end
  endfunction

  function int unsigned outstanding();
    return owed_sums.size();
  endfunction
endclass

module testbench;
  localparam int LB = psu_pkg::LIMIT_BITS_DEF;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic [LB-1:0]             limit;
  logic                      busy;
  logic                      done;
  logic [psu_pkg::SUM_W-1:0] prime_sum;

  prime_sum_tracker tracker;

  longint unsigned cycle_count;
  longint unsigned cycle_budget;
  int unsigned     words_sent;
  int unsigned     directed_words;
  int unsigned     largest_limit;

  prime_sum_up_to_limit #(.LIMIT_BITS(LB)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .limit     (limit),
    .busy      (busy),
    .done      (done),
    .prime_sum (prime_sum)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Rough ceiling on the cycles one word may take: every candidate up to n
  // trying every odd divisor below half of itself, each at the remainder unit's cost,
  // which sits well above the true count of about n*n/(8 ln n) trials.
  function automatic longint unsigned word_ceiling(int unsigned n);
    longint unsigned b;
    b = n;
    return ((b * b) / 8 + 4 * b + 16) * (LB + 8) + 200;
  endfunction

  // Monitor the handshake on the rising edge: note each accepted limit word
  // and widen the watchdog by that word's ceiling.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      tracker.note_limit(limit);
      cycle_budget += word_ceiling(limit);
      if (limit > largest_limit) largest_limit = limit;
    end
  end

  // Check each strobed sum; the receiver cannot hold it off, so take it now.
  always @(posedge clk) begin
    if (!rst && done) tracker.check_sum(prime_sum);
  end

  // Watchdog: stop the run once the cycle count passes the budget.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_budget) begin
      $display("%0t: timeout after %0d cycles, %0d sums outstanding",
               $time, cycle_count, tracker.outstanding());
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one limit word. Hold start low for a random number of cycles
  // (idle_pct in a hundred), putting noise on limit meanwhile, then raise
  // start and hold it until the block takes the word. Called and returns
  // on a falling edge, so start is assigned at most once per time step and
  // stays high straight through into the next word when there is no gap.
  task automatic send_word(input logic [LB-1:0] n, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      limit <= LB'($urandom);
      @(negedge clk);
    end
    start <= 1'b1;
    limit <= n;
    do @(posedge clk); while (busy);
    @(negedge clk);
    words_sent++;
  endtask

  // Mostly small limits keep the run short; the rest reach into the hundreds, up to 1023.
  function automatic logic [LB-1:0] pick_limit();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return LB'($urandom_range(127));
    if (r < 95) return LB'($urandom_range(511, 128));
    return LB'($urandom_range(1023, 512));
  endfunction

  // Directed words: zero and one give an empty sum, two is the only even
  // prime, then small primes, odd composites where the divisor bound first
  // matters (nine, twenty-five, squares of larger primes), a value just
  // past a prime, and finally the largest limit, all ones. Bits above the
  // limit width cannot be driven through a twelve-bit port.
  logic [LB-1:0] directed_limits[] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 13, 15, 17, 24, 25, 26,
    49, 120, 121, 169, 255, 1024, 4095
  };

  int unsigned idle_by_phase[4] = '{0, 75, 0, 14};

  initial begin
    tracker        = new();
    cycle_count    = 0;
    cycle_budget   = 1000;
    words_sent     = 0;
    largest_limit  = 0;
    directed_words = directed_limits.size();
    rst   = 1'b1;
    start = 1'b0;
    limit = '0;

    // Hold reset, then release it on a falling edge.
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_limits[k]) send_word(directed_limits[k], 0);

    // Four idling phases of nineteen random words each.
    foreach (idle_by_phase[p])
      repeat (19) send_word(pick_limit(), idle_by_phase[p]);

    start <= 1'b0;
    limit <= '0;

    // Drain: wait for every owed sum, then keep watching to catch strays.
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Ran %0d limit words (%0d directed), largest limit %0d, in %0d cycles;",
             words_sent, directed_words, largest_limit, cycle_count);
    $display("compared %0d prime sums over four idling phases, %0d mismatches.",
             tracker.compared, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
